### rtl/core/ppal_pkg.sv
// ----------------------------------------------------------------------------
// ppal_pkg: shared types and constants
// Request and result layouts, command and status codes, CORDIC tables.
// ----------------------------------------------------------------------------
package ppal_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ROT,
    ST_MUL
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [15:0]        heading;
    logic signed [31:0] seg_len;
    logic               backward;
    logic [1:0]         kind;
    logic [31:0]        speed;
    logic signed [31:0] qdist;
  } req_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] heading;
    logic [31:0] seg_len;
    logic [2:0]  dir_kind;
    logic [31:0] speed;
  } seg_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] heading;
    logic [31:0] seg_len;
    logic        backward;
    logic [1:0]  kind;
    logic [31:0] speed;
    logic [10:0] count;
    status_t     status;
  } res_t;

  localparam int TOTAL_W = 42;
  localparam logic signed [28:0] INV_GAIN = 29'sd163008219;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/path_point_at_length_top.sv
// Timing: clear and append answer straight from the request, with the result
// registered; a query walks the segments (one per cycle through the store's
// registered read port), then runs the CORDIC steps and the gain multiply.
// Throughput: one request in flight in the engine; a two-entry queue in front.
// Reset: synchronous, clears the segment count, the running total and queues.
// ----------------------------------------------------------------------------
// path_point_at_length_top: point along a stored path at a given length
// Front queue plus store and query engine, streaming in and out.
// ----------------------------------------------------------------------------
module path_point_at_length_top #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x, start_y, heading_in, segment_length, backward_in, section_kind,
  // speed_in, query_distance, zero pad
  input  logic [183:0] s_axis_tdata,
  // cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_x, result_y, result_heading, result_length, result_backward,
  // result_kind, result_speed, segment_count, status
  output logic [159:0] m_axis_tdata
);

  logic           q_valid;
  ppal_pkg::req_t q_req;
  logic           q_pop;
  ppal_pkg::res_t res;

  ppal_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  ppal_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {res.status, res.count, res.speed, res.kind, res.backward,
                         res.seg_len, res.heading, res.y, res.x};

`ifndef SYNTHESIS
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status == ppal_pkg::STAT_EMPTY |-> res.count == 11'd0)
    else $error("empty status with stored segments");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status == ppal_pkg::STAT_FULL |-> res.count == 11'(MAX_SEGMENTS))
    else $error("full status below capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status != ppal_pkg::STAT_OK |-> res.x == '0 && res.speed == '0)
    else $error("payload not cleared on error status");
`endif

endmodule

### rtl/core/ppal_front.sv
// ----------------------------------------------------------------------------
// ppal_front: request intake
// Unpacks and classifies incoming requests into a two-entry queue.
// ----------------------------------------------------------------------------
module ppal_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [183:0]    in_data,
  input  logic [1:0]      in_user,
  output logic            q_valid,
  output ppal_pkg::req_t  q_req,
  input  logic            q_pop
);

  ppal_pkg::req_t fifo [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  ppal_pkg::req_t req;
  logic           push;

  always_comb begin
    req.cmd      = ppal_pkg::cmd_t'(in_user);
    req.start_x  = in_data[31:0];
    req.start_y  = in_data[63:32];
    req.heading  = in_data[79:64];
    req.seg_len  = in_data[111:80];
    req.backward = in_data[112];
    req.kind     = in_data[114:113];
    req.speed    = in_data[146:115];
    req.qdist    = in_data[178:147];
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_req    = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### rtl/core/ppal_back.sv
// ----------------------------------------------------------------------------
// ppal_back: segment store and query engine
// Holds the segments, walks them for a query, rotates the offset by CORDIC.
// ----------------------------------------------------------------------------
module ppal_back #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ppal_pkg::req_t  q_req,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output ppal_pkg::res_t  out_res
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
  localparam logic [SW-1:0] LAST_IT = SW'(CORDIC_STEPS - 1);

  ppal_pkg::state_t state, state_next;

  ppal_pkg::seg_t mem [MAX_SEGMENTS];
  ppal_pkg::seg_t rdata;
  ppal_pkg::seg_t sel;
  ppal_pkg::seg_t wseg;

  logic [CW-1:0] count;
  logic [ppal_pkg::TOTAL_W-1:0] total;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] ev_idx;
  logic          pend;
  logic [ppal_pkg::TOTAL_W-1:0] rem;

  logic signed [39:0] cx, cy;
  logic signed [33:0] cz;
  logic [SW-1:0]      it;
  logic [2:0]         mstep;
  logic signed [53:0] preg, acc;
  logic [31:0]        dx;

  logic        start;
  logic        appending;
  logic [31:0] mag;
  logic        hit;
  logic [ppal_pkg::TOTAL_W-1:0] rem_fin;
  logic [32:0] remc;
  logic signed [39:0] x0;
  logic signed [33:0] z0;
  logic [31:0] nmag;
  logic [ppal_pkg::TOTAL_W:0] tsum;
  logic [ppal_pkg::TOTAL_W-1:0] qclamp;
  logic signed [24:0] mop;
  logic signed [53:0] mprod;
  logic signed [71:0] rsum;
  logic [31:0] rnd;
  logic signed [39:0] xsh, ysh;
  logic signed [33:0] at;
  logic [31:0] cnt32;
  ppal_pkg::res_t res_imm;

  // ---- control ----
  assign start = (state == ppal_pkg::ST_IDLE) && q_valid && !out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ppal_pkg::ST_IDLE:
        if (start && q_req.cmd == ppal_pkg::CMD_QUERY && count != '0) begin
          state_next = ppal_pkg::ST_WALK;
        end
      ppal_pkg::ST_WALK:
        if (pend && hit) begin
          state_next = ppal_pkg::ST_ROT;
        end
      ppal_pkg::ST_ROT:
        if (it == LAST_IT) begin
          state_next = ppal_pkg::ST_MUL;
        end
      ppal_pkg::ST_MUL:
        if (mstep == 3'd4) begin
          state_next = ppal_pkg::ST_IDLE;
        end
      default: state_next = ppal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = start;
    appending = start && q_req.cmd == ppal_pkg::CMD_APPEND && count < MAX_CNT;
  end

  // ---- store ----
  always_comb begin
    wseg.x        = q_req.start_x;
    wseg.y        = q_req.start_y;
    wseg.heading  = q_req.heading;
    wseg.seg_len  = q_req.seg_len;
    wseg.dir_kind = {q_req.kind, q_req.backward};
    wseg.speed    = q_req.speed;
  end

  always_ff @(posedge clk) begin
    if (appending) begin
      mem[count[AW-1:0]] <= wseg;
    end
    rdata <= mem[rd_idx[AW-1:0]];
  end

  // ---- datapath ----
  always_comb begin
    mag     = rdata.seg_len[31] ? (32'd0 - rdata.seg_len) : rdata.seg_len;
    hit     = ({10'd0, mag} >= rem) || (ev_idx == count - CW'(1));
    rem_fin = ({10'd0, mag} < rem) ? rem - {10'd0, mag} : rem;
    remc    = (rem_fin > 42'h1_0000_0000) ? 33'h1_0000_0000 : rem_fin[32:0];
    x0      = rdata.dir_kind[0] ? -$signed({7'd0, remc} <<< 2)
                                :  $signed({7'd0, remc} <<< 2);
    z0      = 34'($signed({rdata.heading, 16'd0}));
    nmag    = q_req.seg_len[31] ? (32'd0 - q_req.seg_len) : q_req.seg_len;
    tsum    = {1'b0, total} + {11'd0, nmag};
    if (q_req.qdist[31]) begin
      qclamp = '0;
    end else if ({10'd0, q_req.qdist} > total) begin
      qclamp = total;
    end else begin
      qclamp = {10'd0, q_req.qdist};
    end
    xsh = cx >>> it;
    ysh = cy >>> it;
    at  = $signed({2'b00, ppal_pkg::atan_turn(5'(it))});
    // low halves unsigned, high halves carry the sign
    case (mstep)
      3'd0:    mop = $signed({9'd0, cx[15:0]});
      3'd1:    mop = 25'($signed(cx[39:16]));
      3'd2:    mop = $signed({9'd0, cy[15:0]});
      default: mop = 25'($signed(cy[39:16]));
    endcase
    mprod = mop * ppal_pkg::INV_GAIN;
    rsum  = 72'(acc) + (72'(preg) <<< 16) + 72'sd536870912;
    rnd   = 32'(rsum >>> 30);
    cnt32 = 32'(count);
  end

  // immediate result for everything but a walked query
  always_comb begin
    res_imm        = '0;
    res_imm.count  = cnt32[10:0];
    res_imm.status = ppal_pkg::STAT_OK;
    case (q_req.cmd)
      ppal_pkg::CMD_CLEAR: res_imm.count = 11'd0;
      ppal_pkg::CMD_APPEND:
        if (appending) begin
          res_imm.count = 11'(cnt32 + 32'd1);
        end else begin
          res_imm.status = ppal_pkg::STAT_FULL;
        end
      ppal_pkg::CMD_QUERY:
        if (count == '0) begin
          res_imm.status = ppal_pkg::STAT_EMPTY;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppal_pkg::ST_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        case (q_req.cmd)
          ppal_pkg::CMD_CLEAR: begin
            count <= '0;
            total <= '0;
          end
          ppal_pkg::CMD_APPEND:
            if (appending) begin
              count <= count + CW'(1);
              total <= tsum[ppal_pkg::TOTAL_W] ? '1 : tsum[ppal_pkg::TOTAL_W-1:0];
            end
          default: ;
        endcase
        if (!(q_req.cmd == ppal_pkg::CMD_QUERY && count != '0)) begin
          out_valid <= 1'b1;
        end
      end
      if (state == ppal_pkg::ST_MUL && mstep == 3'd4) begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      out_res <= res_imm;
      rem     <= qclamp;
      rd_idx  <= '0;
      pend    <= 1'b0;
    end
    if (state == ppal_pkg::ST_WALK) begin
      rd_idx <= rd_idx + CW'(1);
      ev_idx <= rd_idx;
      pend   <= 1'b1;
      if (pend) begin
        rem <= rem_fin;
        if (hit) begin
          sel <= rdata;
          it  <= '0;
          cy  <= '0;
          if (z0 > 34'sh0_4000_0000) begin
            cx <= -x0;
            cz <= z0 - 34'sh0_8000_0000;
          end else if (z0 < -34'sh0_4000_0000) begin
            cx <= -x0;
            cz <= z0 + 34'sh0_8000_0000;
          end else begin
            cx <= x0;
            cz <= z0;
          end
        end
      end
    end
    if (state == ppal_pkg::ST_ROT) begin
      it    <= it + SW'(1);
      mstep <= '0;
      if (!cz[33]) begin
        cx <= cx - ysh;
        cy <= cy + xsh;
        cz <= cz - at;
      end else begin
        cx <= cx + ysh;
        cy <= cy - xsh;
        cz <= cz + at;
      end
    end
    if (state == ppal_pkg::ST_MUL) begin
      mstep <= mstep + 3'd1;
      preg  <= mprod;
      if (mstep == 3'd1 || mstep == 3'd3) begin
        acc <= preg;
      end
      if (mstep == 3'd2) begin
        dx <= rnd;
      end
      if (mstep == 3'd4) begin
        out_res.x        <= sel.x + dx;
        out_res.y        <= sel.y + rnd;
        out_res.heading  <= sel.heading;
        out_res.seg_len  <= sel.seg_len;
        out_res.backward <= sel.dir_kind[0];
        out_res.kind     <= sel.dir_kind[2:1];
        out_res.speed    <= sel.speed;
        out_res.count    <= cnt32[10:0];
        out_res.status   <= ppal_pkg::STAT_OK;
      end
    end
  end

endmodule
